### rtl/hptte_pkg.sv
// shared widths, payload structs and helper functions for the even-q hex tile mapper
// no dependencies; every other file of the block imports this package
package hptte_pkg;

  localparam int COORD_BITS     = 16;
  localparam int TILE_SIZE_BITS = 10;

  // signed working width of the shifted y coordinate, also the dividend width
  localparam int DVD_W = ((COORD_BITS > TILE_SIZE_BITS) ? COORD_BITS : TILE_SIZE_BITS) + 1;
  // column period 3h/2 stays below twice the largest tile size
  localparam int PX_W  = TILE_SIZE_BITS + 1;
  // floor quotient, signed
  localparam int Q_W   = DVD_W;
  // remainder tests and unsaturated results
  localparam int CMP_W = PX_W + 3;
  localparam int RES_W = Q_W + 2;

  // restoring divider: quotient bits per pipeline stage
  localparam int BPS        = 2;
  localparam int DIV_STAGES = (DVD_W + BPS - 1) / BPS;

  localparam logic [TILE_SIZE_BITS-1:0] TILE_SIZE_RESET = TILE_SIZE_BITS'(72);
  localparam logic [TILE_SIZE_BITS-1:0] TILE_SIZE_MIN   = TILE_SIZE_BITS'(2);

  typedef struct packed {
    logic [DVD_W-1:0]          x_mag;
    logic                      x_neg;
    logic [DVD_W-1:0]          y_mag;
    logic                      y_neg;
    logic [PX_W-1:0]           px;
    logic [TILE_SIZE_BITS-1:0] h;
    logic [TILE_SIZE_BITS-2:0] half;
  } prep_t;

  typedef struct packed {
    logic [PX_W-1:0]           x_rem;
    logic [DVD_W-1:0]          x_dvd;
    logic [PX_W-1:0]           y_rem;
    logic [DVD_W-1:0]          y_dvd;
    logic                      x_neg;
    logic                      y_neg;
    logic [PX_W-1:0]           px;
    logic [TILE_SIZE_BITS-1:0] h;
    logic [TILE_SIZE_BITS-2:0] half;
  } div_t;

  typedef struct packed {
    logic signed [Q_W-1:0]     qx;
    logic signed [Q_W-1:0]     qy;
    logic [PX_W-1:0]           rx;
    logic [PX_W-1:0]           ry;
    logic [PX_W-1:0]           px;
    logic [TILE_SIZE_BITS-1:0] h;
    logic [TILE_SIZE_BITS-2:0] half;
  } flr_t;

  // BPS restoring steps; the dividend shifts out msb first, quotient bits shift in at lsb
  function automatic logic [PX_W+DVD_W-1:0] div_steps(input logic [PX_W-1:0]  rem,
                                                      input logic [DVD_W-1:0] dvd,
                                                      input logic [PX_W-1:0]  dsr,
                                                      input int               first);
    logic [PX_W:0]    trial;
    logic [PX_W-1:0]  r;
    logic [DVD_W-1:0] q;
    r = rem;
    q = dvd;
    for (int i = 0; i < BPS; i++) begin
      if (first + i < DVD_W) begin
        trial = {r, q[DVD_W-1]};
        q     = {q[DVD_W-2:0], 1'b0};
        if (trial >= {1'b0, dsr}) begin
          trial = trial - {1'b0, dsr};
          q[0]  = 1'b1;
        end
        r = trial[PX_W-1:0];
      end
    end
    return {r, q};
  endfunction

  // clamp to the signed coordinate range
  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [RES_W-1:0] v);
    logic [RES_W-COORD_BITS:0] hi_bits;
    hi_bits = v[RES_W-1:COORD_BITS-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      return v[COORD_BITS-1:0];
    end else if (v[RES_W-1]) begin
      return {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/hptte_if.sv
// valid/ready channel interfaces for pixel positions in and tile indexes out
// depends on hptte_pkg for the coordinate width
interface hptte_in_if import hptte_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface hptte_out_if import hptte_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] tile_col;
  logic signed [COORD_BITS-1:0] tile_row;

  modport source (output valid, output tile_col, output tile_row, input ready);
  modport sink   (input valid, input tile_col, input tile_row, output ready);
endinterface

### rtl/hptte_prep.sv
// first pipeline stage: tile size clamp, periods, y shift and sign/magnitude split
// depends on hptte_pkg
module hptte_prep import hptte_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] pixel_x_i,
  input  logic signed [COORD_BITS-1:0] pixel_y_i,
  input  logic [TILE_SIZE_BITS-1:0]    tile_size_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output prep_t                        data_o
);

  logic                      valid_q;
  prep_t                     data_q, data_d;
  logic [TILE_SIZE_BITS-1:0] h;
  logic [DVD_W-1:0]          x_ext, y_ext, y_sh;

  assign h = (tile_size_i < TILE_SIZE_MIN) ? TILE_SIZE_MIN : tile_size_i;

  always_comb begin
    x_ext = {{(DVD_W-COORD_BITS){pixel_x_i[COORD_BITS-1]}}, pixel_x_i};
    y_ext = {{(DVD_W-COORD_BITS){pixel_y_i[COORD_BITS-1]}}, pixel_y_i};
    data_d.h    = h;
    data_d.half = h[TILE_SIZE_BITS-1:1];
    data_d.px   = PX_W'(h) + PX_W'(h[TILE_SIZE_BITS-1:1]);
    y_sh        = y_ext - DVD_W'(h[TILE_SIZE_BITS-1:1]);
    // negative values divide as ~a, the floor fix later undoes it
    data_d.x_neg = x_ext[DVD_W-1];
    data_d.x_mag = x_ext[DVD_W-1] ? ~x_ext : x_ext;
    data_d.y_neg = y_sh[DVD_W-1];
    data_d.y_mag = y_sh[DVD_W-1] ? ~y_sh : y_sh;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/hptte_div.sv
// pipelined restoring divider, x by the column period and y by the tile size in parallel
// depends on hptte_pkg; BPS quotient bits per stage
module hptte_div import hptte_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  prep_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output div_t  data_o
);

  logic [DIV_STAGES-1:0] valid_q;
  logic [DIV_STAGES:0]   rdy;
  logic [DIV_STAGES-1:0] src_valid;
  div_t                  data_q [DIV_STAGES];
  div_t                  src    [DIV_STAGES];
  div_t                  data_d [DIV_STAGES];
  div_t                  init;

  always_comb begin
    init.x_rem = '0;
    init.x_dvd = data_i.x_mag;
    init.y_rem = '0;
    init.y_dvd = data_i.y_mag;
    init.x_neg = data_i.x_neg;
    init.y_neg = data_i.y_neg;
    init.px    = data_i.px;
    init.h     = data_i.h;
    init.half  = data_i.half;
  end

  // stage ready: empty, or its item moves on this cycle
  always_comb begin
    rdy[DIV_STAGES] = ready_i;
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      rdy[s] = !valid_q[s] || rdy[s+1];
    end
  end

  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        src[s]       = init;
        src_valid[s] = valid_i;
      end else begin
        src[s]       = data_q[s-1];
        src_valid[s] = valid_q[s-1];
      end
      data_d[s] = src[s];
      {data_d[s].x_rem, data_d[s].x_dvd} =
        div_steps(src[s].x_rem, src[s].x_dvd, src[s].px, s * BPS);
      {data_d[s].y_rem, data_d[s].y_dvd} =
        div_steps(src[s].y_rem, src[s].y_dvd, PX_W'(src[s].h), s * BPS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        if (rdy[s]) begin
          valid_q[s] <= src_valid[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (rdy[s] && src_valid[s]) begin
        data_q[s] <= data_d[s];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = valid_q[DIV_STAGES-1];
  assign data_o  = data_q[DIV_STAGES-1];

`ifndef SYNTHESIS
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[DIV_STAGES-1] && !ready_i |=> valid_q[DIV_STAGES-1])
    else $error("divider dropped a stalled item");
`endif

endmodule

### rtl/hptte_fix.sv
// last two stages: floor correction of quotients, then hex corrections and saturation
// depends on hptte_pkg; stage b is the output register
module hptte_fix import hptte_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  div_t                         data_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [COORD_BITS-1:0] tile_col_o,
  output logic signed [COORD_BITS-1:0] tile_row_o
);

  logic                    a_valid_q, b_valid_q;
  logic                    rdy_a, rdy_b;
  flr_t                    flr_q, flr_d;
  logic [COORD_BITS-1:0]   col_q, col_d, row_q, row_d;
  logic signed [CMP_W-1:0] rx2, ryv, halfv, pxv, h2, dv;
  logic signed [RES_W-1:0] col_base, row_base, col_v, row_v;
  logic                    col_dec, col_inc, row_inc;

  // stage a: floor(a/p) = -(~a / p) - 1 = ~q', remainder p - 1 - r'
  always_comb begin
    flr_d.qx   = data_i.x_neg ? ~data_i.x_dvd : data_i.x_dvd;
    flr_d.qy   = data_i.y_neg ? ~data_i.y_dvd : data_i.y_dvd;
    flr_d.rx   = data_i.x_neg ? (data_i.px - PX_W'(1) - data_i.x_rem) : data_i.x_rem;
    flr_d.ry   = data_i.y_neg ? (PX_W'(data_i.h) - PX_W'(1) - data_i.y_rem) : data_i.y_rem;
    flr_d.px   = data_i.px;
    flr_d.h    = data_i.h;
    flr_d.half = data_i.half;
  end

  // stage b: linear edge tests on the remainders
  always_comb begin
    rx2   = CMP_W'({flr_q.rx, 1'b0});
    ryv   = CMP_W'(flr_q.ry);
    halfv = CMP_W'(flr_q.half);
    pxv   = CMP_W'(flr_q.px);
    h2    = CMP_W'({flr_q.h, 1'b0});
    dv    = ryv - halfv;
    col_dec = 1'b0;
    col_inc = 1'b0;
    row_inc = 1'b0;
    if (ryv < halfv) begin
      // upper half-row
      if (rx2 + ryv < halfv) begin
        col_dec = 1'b1;
      end else if (rx2 - ryv >= pxv) begin
        col_inc = 1'b1;
      end
    end else begin
      // lower half-row, neighbors sit one row down
      if (rx2 < dv) begin
        col_dec = 1'b1;
        row_inc = 1'b1;
      end else if (rx2 + dv >= h2) begin
        col_inc = 1'b1;
        row_inc = 1'b1;
      end
    end
    col_base = {flr_q.qx[Q_W-1], flr_q.qx, 1'b0};
    row_base = {{2{flr_q.qy[Q_W-1]}}, flr_q.qy};
    if (col_dec) begin
      col_v = col_base - RES_W'(1);
    end else if (col_inc) begin
      col_v = col_base + RES_W'(1);
    end else begin
      col_v = col_base;
    end
    row_v = row_inc ? (row_base + RES_W'(1)) : row_base;
    col_d = sat_coord(col_v);
    row_d = sat_coord(row_v);
  end

  assign rdy_b   = !b_valid_q || ready_i;
  assign rdy_a   = !a_valid_q || rdy_b;
  assign ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_valid_q <= valid_i;
      end
      if (rdy_b) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      flr_q <= flr_d;
    end
    if (rdy_b && a_valid_q) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign valid_o    = b_valid_q;
  assign tile_col_o = col_q;
  assign tile_row_o = row_q;

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> (flr_q.rx < flr_q.px) && (flr_q.ry < PX_W'(flr_q.h)))
    else $error("floor remainder out of range");
`endif

endmodule

### rtl/hex_pixel_to_tile_evenq.sv
// top level of the even-q hex pixel-to-tile mapper
// depends on hptte_pkg, hptte_if, hptte_prep, hptte_div and hptte_fix
//
// usage
// - pix_i carries one signed pixel position (pixel_x, pixel_y) per transfer,
//   tile_o returns the flat-top even-q tile (tile_col, tile_row) that holds it,
//   one result per position, in order, saturated to the coordinate range
// - tile_size_i is the tile height h, written when tile_size_we_i is high;
//   change it only while no positions are in flight; 0 and 1 act as 2
// - pipeline: 3 + DIV_STAGES register stages (prep, DIV_STAGES divider stages of
//   BPS quotient bits, floor fix, correction/output register)
// - throughput: one position per cycle while the sink takes results; both divisions
//   run in the shared divider pipeline, x by 3h/2 and the shifted y by h
// - every stage carries its own valid bit and takes a new item when it is
//   empty or its item moves on, so bubbles fill while the sink stalls
// - a receiver stall holds the output register; the stall reaches pix_i only
//   once all stages hold items, nothing is dropped or repeated
// - reset clears all valid bits and loads the tile size with 72; no
//   clearing pass, the block takes input in the first cycle after reset
module hex_pixel_to_tile_evenq import hptte_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tile_size_we_i,
  input  logic [TILE_SIZE_BITS-1:0] tile_size_i,
  hptte_in_if.sink                  pix_i,
  hptte_out_if.source               tile_o
);

  // tile size register
  logic [TILE_SIZE_BITS-1:0] tile_size_q;

  // stage to stage handshake
  logic  prep_valid, prep_ready;
  prep_t prep_data;
  logic  div_valid, div_ready;
  div_t  div_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q <= TILE_SIZE_RESET;
    end else if (tile_size_we_i) begin
      tile_size_q <= tile_size_i;
    end
  end

  // periods, shifted y, magnitudes
  hptte_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (pix_i.valid),
    .ready_o     (pix_i.ready),
    .pixel_x_i   (pix_i.pixel_x),
    .pixel_y_i   (pix_i.pixel_y),
    .tile_size_i (tile_size_q),
    .valid_o     (prep_valid),
    .ready_i     (prep_ready),
    .data_o      (prep_data)
  );

  // quotient and remainder of both coordinates
  hptte_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .data_i  (prep_data),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .data_o  (div_data)
  );

  // floor fix, hex edge corrections, saturation, output register
  hptte_fix u_fix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (div_valid),
    .ready_o    (div_ready),
    .data_i     (div_data),
    .valid_o    (tile_o.valid),
    .ready_i    (tile_o.ready),
    .tile_col_o (tile_o.tile_col),
    .tile_row_o (tile_o.tile_row)
  );

`ifndef SYNTHESIS
  // input backpressure only comes from a stalled, full output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> tile_o.valid && !tile_o.ready)
    else $error("input stalled without output stall");
`endif

`ifndef SYNTHESIS
  // tile size moves only on a write
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(tile_size_we_i) |-> $stable(tile_size_q))
    else $error("tile size changed without a write");
`endif

endmodule

### verif/tb_hex_pixel_to_tile_evenq.sv
// testbench for the even-q hex pixel-to-tile mapper: streams pixel positions, checks tile indexes
// depends on hptte_pkg, hptte_if and the hex_pixel_to_tile_evenq top level
// a class keeps its own tile size and the queue of expected tiles in transfer order
module tb_hex_pixel_to_tile_evenq;
  import hptte_pkg::*;

  // pipeline depth from the block header plus some slack for draining
  localparam int FLUSH_CYCLES   = 3 + DIV_STAGES + 8;
  localparam int RAND_PER_PHASE = 130;
  localparam int NUM_PHASES     = 8;
  localparam int LONG_HOLD      = 400;

  typedef struct {
    logic signed [COORD_BITS-1:0] col;
    logic signed [COORD_BITS-1:0] row;
  } tile_t;

  // expected tiles for accepted positions, with a private copy of the tile size
  class tile_checker;
    logic [TILE_SIZE_BITS-1:0] tile_size;
    tile_t                     expected_tiles[$];
    int                        errors;

    function new();
      tile_size = TILE_SIZE_BITS'(72);
      errors    = 0;
    endfunction

    function void set_tile_size(input logic [TILE_SIZE_BITS-1:0] v);
      tile_size = v;
    endfunction

    // sizes 0 and 1 behave as 2
    function longint eff_h();
      longint h;
      h = longint'(tile_size);
      if (h < 2) h = 2;
      return h;
    endfunction

    function logic signed [COORD_BITS-1:0] clamp(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return COORD_BITS'(v);
    endfunction

    // floor division into a quotient and a non-negative remainder
    function void floor_div(input longint a, input longint p, output longint q,
                            output longint r);
      q = a / p;
      r = a % p;
      if (r < 0) begin
        r = r + p;
        q = q - 1;
      end
    endfunction

    function tile_t map_to_tile(input logic signed [COORD_BITS-1:0] x_in,
                                input logic signed [COORD_BITS-1:0] y_in);
      longint h, half, px, qx, rx, qy, ry, col, row, d;
      tile_t  t;
      h    = eff_h();
      half = h / 2;
      px   = (3 * h) / 2;
      floor_div(longint'(x_in), px, qx, rx);
      floor_div(longint'(y_in) - half, h, qy, ry);
      col = 2 * qx;
      row = qy;
      if (ry < half) begin
        // upper half-row: only the column moves
        if (rx * 2 + ry < half) col = col - 1;
        else if (rx * 2 - ry >= (h * 3) / 2) col = col + 1;
      end else begin
        // lower half-row: a side neighbor also steps one row down
        d = ry - half;
        if (rx * 2 - d < 0) begin
          col = col - 1;
          row = row + 1;
        end else if (rx * 2 + d >= h * 2) begin
          col = col + 1;
          row = row + 1;
        end
      end
      t.col = clamp(col);
      t.row = clamp(row);
      return t;
    endfunction

    function void note_position(input logic signed [COORD_BITS-1:0] x_in,
                                input logic signed [COORD_BITS-1:0] y_in);
      expected_tiles.push_back(map_to_tile(x_in, y_in));
    endfunction

    function void check_tile(input logic signed [COORD_BITS-1:0] col,
                             input logic signed [COORD_BITS-1:0] row);
      tile_t e;
      if (expected_tiles.size() == 0) begin
        $error("unexpected tile transfer: col %0d row %0d", col, row);
        errors++;
        return;
      end
      e = expected_tiles.pop_front();
      if (col !== e.col) begin
        $error("tile_col mismatch: expected %0d, got %0d", e.col, col);
        errors++;
      end
      if (row !== e.row) begin
        $error("tile_row mismatch: expected %0d, got %0d", e.row, row);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_tiles.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      tile_size_we;
  logic [TILE_SIZE_BITS-1:0] tile_size_wdata;

  hptte_in_if  pix_if ();
  hptte_out_if tile_if ();

  tile_checker sb = new();

  // idle percentages for each side, changed only between phases
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int unsigned long_hold_req = 0;

  hex_pixel_to_tile_evenq u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .tile_size_we_i (tile_size_we),
    .tile_size_i    (tile_size_wdata),
    .pix_i          (pix_if.sink),
    .tile_o         (tile_if.source)
  );

  // period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: check each tile transfer, then decide ready for the next edge
  always @(posedge clk) begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    if (rst_n === 1'b1 && tile_if.valid && tile_if.ready) begin
      sb.check_tile(tile_if.tile_col, tile_if.tile_row);
    end
    // a new hold-off request starts a long stretch with ready low
    if (long_hold_req != hold_seen) begin
      hold_seen = long_hold_req;
      hold_left = LONG_HOLD;
    end
    if (rst_n !== 1'b1) begin
      tile_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      tile_if.ready <= 1'b0;
    end else begin
      tile_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // random coordinate: raw bits, near a period edge, inside one cell, or an extreme
  function automatic logic signed [COORD_BITS-1:0] pick_coord(input longint period,
                                                              input longint shift);
    longint lim, k, v;
    lim = (longint'(1) <<< (COORD_BITS - 1)) / period + 1;
    k   = longint'($urandom_range(0, 2 * lim)) - lim;
    case ($urandom_range(4))
      0, 1: return COORD_BITS'($urandom);
      2: v = k * period + shift + longint'($urandom_range(0, 6)) - 3;
      3: v = k * period + shift + longint'($urandom_range(0, period - 1));
      default: begin
        // extremes, the value right next to the negative one, and zero
        case ($urandom_range(3))
          0: return {1'b0, {(COORD_BITS-1){1'b1}}};
          1: return {1'b1, {(COORD_BITS-1){1'b0}}};
          2: return {1'b1, {(COORD_BITS-2){1'b0}}, 1'b1};
          default: return '0;
        endcase
      end
    endcase
    if (v > (longint'(1) <<< (COORD_BITS - 1)) - 1 || v < -(longint'(1) <<< (COORD_BITS - 1)))
      return COORD_BITS'($urandom);
    return COORD_BITS'(v);
  endfunction

  // one position transfer; returns in the step of the accepting edge
  task automatic send_position(input logic signed [COORD_BITS-1:0] x,
                               input logic signed [COORD_BITS-1:0] y);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid   <= 1'b1;
    pix_if.pixel_x <= x;
    pix_if.pixel_y <= y;
    do @(posedge clk); while (!pix_if.ready);
    sb.note_position(x, y);
  endtask

  // stop offering, wait for every expected tile, then let the pipeline settle
  task automatic drain();
    pix_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  // register write lands at the next edge; the block is empty here
  task automatic write_tile_size(input logic [TILE_SIZE_BITS-1:0] v);
    tile_size_we    <= 1'b1;
    tile_size_wdata <= v;
    @(posedge clk);
    sb.set_tile_size(v);
    tile_size_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [TILE_SIZE_BITS-1:0] sizes[NUM_PHASES];
    longint                    h;
    rst_n           = 1'b0;
    tile_size_we    = 1'b0;
    tile_size_wdata = '0;
    pix_if.valid    = 1'b0;
    pix_if.pixel_x  = '0;
    pix_if.pixel_y  = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed positions at the reset tile size 72: column period 108, half 36
    send_position(16'sd0, 16'sd0);
    send_position(16'sd32767, 16'sd32767);
    send_position(-16'sd32768, -16'sd32768);
    send_position(16'sd32767, -16'sd32768);
    send_position(-16'sd32768, 16'sd32767);
    send_position(-16'sd1, -16'sd1);
    // exact negative multiples of both periods, remainder must be zero
    send_position(-16'sd108, -16'sd36);
    send_position(-16'sd216, -16'sd108);
    send_position(-16'sd32724, -16'sd32724);
    // just below and on period edges
    send_position(16'sd107, 16'sd35);
    send_position(16'sd108, 16'sd36);
    send_position(-16'sd1, 16'sd35);
    send_position(16'sd0, 16'sd36);
    // near the slanted edges of the upper and lower half-rows
    send_position(16'sd17, 16'sd37);
    send_position(16'sd18, 16'sd36);
    send_position(16'sd91, 16'sd72);
    send_position(16'sd90, 16'sd71);
    send_position(16'sd1, 16'sd71);
    drain();

    // reset value, smallest, largest, the two values that act as 2, odd, random
    sizes[0] = TILE_SIZE_BITS'(72);
    sizes[1] = TILE_SIZE_BITS'(2);
    sizes[2] = TILE_SIZE_BITS'(1023);
    sizes[3] = TILE_SIZE_BITS'(0);
    sizes[4] = TILE_SIZE_BITS'(1);
    sizes[5] = TILE_SIZE_BITS'(3);
    sizes[6] = TILE_SIZE_BITS'($urandom_range(2, 1023));
    sizes[7] = TILE_SIZE_BITS'($urandom_range(4, 40));

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) write_tile_size(sizes[p]);
      // sender rarely idles first, then the receiver rarely idles, then no idling
      if (p < 3) begin
        src_idle_pct <= 8;
        snk_idle_pct <= 82;
      end else if (p < 6) begin
        src_idle_pct <= 82;
        snk_idle_pct <= 8;
      end else begin
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
      end
      // long receiver hold-off while the sender keeps offering: fills the pipeline
      if (p == 6) long_hold_req <= long_hold_req + 1;
      h = sb.eff_h();
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        send_position(pick_coord((3 * h) / 2, 0), pick_coord(h, h / 2));
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // generous guard against a hung handshake
  initial begin : watchdog
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
rtl/hptte_pkg.sv
rtl/hptte_if.sv
rtl/hptte_prep.sv
rtl/hptte_div.sv
rtl/hptte_fix.sv
rtl/hex_pixel_to_tile_evenq.sv
verif/tb_hex_pixel_to_tile_evenq.sv
